### rtl/bbc_pkg.sv
// Package for the block buffer cache: codes, widths and shared types.
package bbc_pkg;

    typedef enum logic [2:0] {
        MODE_GET     = 3'd0,
        MODE_RELEASE = 3'd1,
        MODE_PIN     = 3'd2,
        MODE_UNPIN   = 3'd3,
        MODE_RANGE   = 3'd4
    } t_mode;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_UNDER  = 2'd2;
    localparam logic [1:0] ST_OVER   = 2'd3;

    localparam int          REFS_W   = 16;
    localparam logic [15:0] REFS_MAX = 16'hFFFF;

    // Per-entry metadata read by the scan comparator.
    typedef struct packed {
        logic        is_tagged;
        logic        valid;
        logic [15:0] refs;
    } t_meta;

    // Response fields, lowest bit first: slot, was_hit, fill, range_hit, status.
    typedef struct packed {
        logic [1:0] status;
        logic       range_hit;
        logic       fill_needed;
        logic       was_hit;
        logic [6:0] slot;
    } t_result;

endpackage

### rtl/bbc_cmp.sv
// Shared entry comparator: tag match, range window test and free-victim test.
module bbc_cmp
    import bbc_pkg::*;
#(
    parameter int RANK_W = 7
) (
    input  logic [31:0]     i_dev,
    input  logic [31:0]     i_blk,
    input  logic [8:0]      i_run,
    input  logic [31:0]     i_e_dev,
    input  logic [31:0]     i_e_blk,
    input  t_meta           i_meta,
    input  logic [RANK_W-1:0] i_rank,
    input  logic [RANK_W:0] i_best,
    output logic            o_tag_hit,
    output logic            o_rng_hit,
    output logic            o_better
);
    logic [31:0] w_diff;

    // One subtract shared between exact match and window test
    assign w_diff    = i_e_blk - i_blk;
    assign o_tag_hit = i_meta.is_tagged && (i_e_dev == i_dev) && (w_diff == 32'd0);
    assign o_rng_hit = i_meta.is_tagged && i_meta.valid && (i_e_dev == i_dev) &&
                       (w_diff < {23'd0, i_run});
    assign o_better  = (i_meta.refs == '0) && ({1'b0, i_rank} < i_best);
endmodule

### rtl/block_buffer_cache_lru_unit.sv
// Top level of the block buffer cache tag, reference and recency manager.
//  channel | dir | transaction fields (tdata, low bit first)
//  s_axis  | in  | mode[2:0] device[34:3] block[66:35] run[74:67] slot[81:75]
//  m_axis  | out | slot[6:0] was_hit[7] fill[8] range_hit[9] status[11:10]
// Get and range read every entry once, one per cycle, then commit the result
// and load it into the output register. Release, pin and unpin read the slot,
// update it and load the result; a release that drops the count to zero adds a
// rank sweep over every entry. Unknown modes and out-of-range slots go straight
// to the output state. After reset a clearing pass over every entry zeroes flags
// and counts and loads rank = slot; s_axis_tready is high only when idle, and a result waiting
// in the output register holds the sequencer in its output state.
module block_buffer_cache_lru_unit
    import bbc_pkg::*;
#(
    parameter int BUFFER_COUNT = 128,
    parameter int MAX_RUN      = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // mode, block_device, block_number, run_length, slot_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // slot_out, was_hit, fill_needed, range_hit, status
);
    localparam int IDX_W = $clog2(BUFFER_COUNT);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] ENTRIES  = CNT_W'(BUFFER_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_COUNT - 1);
    localparam logic [8:0]       RUN_CAP  = 9'(MAX_RUN);

    typedef enum logic [7:0] {
        S_INIT   = 8'b00000001,
        S_IDLE   = 8'b00000010,
        S_SCAN   = 8'b00000100,
        S_COMMIT = 8'b00001000,
        S_SREAD  = 8'b00010000,
        S_SLOT   = 8'b00100000,
        S_SWEEP  = 8'b01000000,
        S_OUT    = 8'b10000000
    } t_state;

    // Entry storage
    logic [31:0]      r_mdev [BUFFER_COUNT];
    logic [31:0]      r_mblk [BUFFER_COUNT];
    t_meta            r_meta [BUFFER_COUNT];
    logic [IDX_W-1:0] r_rank [BUFFER_COUNT];

    // Registered read data
    logic [31:0]      r_rd_dev, r_rd_blk;
    t_meta            r_rd_meta;
    logic [IDX_W-1:0] r_rd_rank, r_rd_idx;
    logic             r_rd_ok;

    // Sequencer registers
    t_state           r_state;
    t_mode            r_mode;
    logic [31:0]      r_dev, r_blk;
    logic [8:0]       r_run;
    logic [IDX_W-1:0] r_slot;
    logic [CNT_W-1:0] r_idx;
    logic             r_hit, r_rhit;
    logic [IDX_W-1:0] r_found, r_victim, r_mv_rank;
    t_meta            r_hmeta;
    logic [IDX_W:0]   r_best;
    t_result          r_res;
    logic [15:0]      r_out;
    logic             r_out_vld;

    logic [2:0]       w_in_mode;
    logic [7:0]       w_in_run;
    logic [6:0]       w_in_slot;
    logic [IDX_W-1:0] w_raddr;
    logic             w_issue, w_move, w_out_load;
    logic             w_tag_hit, w_rng_hit, w_better;
    logic             w_meta_we, w_rank_we, w_tag_we;
    logic [IDX_W-1:0] w_meta_wa, w_rank_wa, w_rank_wd;
    t_meta            w_meta_wd;
    t_result          w_res;

    assign w_in_mode = s_axis_tdata[2:0];
    assign w_in_run  = s_axis_tdata[74:67];
    assign w_in_slot = s_axis_tdata[81:75];
    assign w_raddr   = r_idx[IDX_W-1:0];
    assign w_issue   = ((r_state == S_SCAN) || (r_state == S_SWEEP)) && (r_idx < ENTRIES);

    bbc_cmp #(.RANK_W(IDX_W)) u_cmp (
        .i_dev(r_dev), .i_blk(r_blk), .i_run(r_run),
        .i_e_dev(r_rd_dev), .i_e_blk(r_rd_blk), .i_meta(r_rd_meta),
        .i_rank(r_rd_rank), .i_best(r_best),
        .o_tag_hit(w_tag_hit), .o_rng_hit(w_rng_hit), .o_better(w_better)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    // Tag memory: retagged on a miss, read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            r_mdev[r_victim] <= r_dev;
            r_mblk[r_victim] <= r_blk;
        end
        r_rd_dev <= r_mdev[w_raddr];
        r_rd_blk <= r_mblk[w_raddr];
    end

    // Metadata memory
    always_ff @(posedge i_clk) begin
        if (w_meta_we) r_meta[w_meta_wa] <= w_meta_wd;
        r_rd_meta <= r_meta[w_raddr];
    end

    // Recency rank memory
    always_ff @(posedge i_clk) begin
        if (w_rank_we) r_rank[w_rank_wa] <= w_rank_wd;
        r_rd_rank <= r_rank[w_raddr];
    end

    // Write and result decisions for the current state
    always_comb begin
        w_meta_we = 1'b0;
        w_meta_wa = r_idx[IDX_W-1:0];
        w_meta_wd = '0;
        w_rank_we = 1'b0;
        w_rank_wa = r_idx[IDX_W-1:0];
        w_rank_wd = r_idx[IDX_W-1:0];
        w_tag_we  = 1'b0;
        w_move    = 1'b0;
        w_res     = '0;
        unique case (r_state)
            S_INIT: begin
                w_meta_we = 1'b1;
                w_rank_we = 1'b1;
            end
            S_COMMIT: begin
                if (r_mode == MODE_RANGE) begin
                    w_res.range_hit = r_rhit;
                end else if (r_hit) begin
                    // Hit: add a reference, saturating
                    w_meta_we           = 1'b1;
                    w_meta_wa           = r_found;
                    w_meta_wd.is_tagged = 1'b1;
                    w_meta_wd.valid     = 1'b1;
                    w_meta_wd.refs      = (r_hmeta.refs == REFS_MAX) ?
                                          REFS_MAX : r_hmeta.refs + 1'b1;
                    w_res.slot          = 7'(r_found);
                    w_res.was_hit       = 1'b1;
                    w_res.fill_needed   = !r_hmeta.valid;
                    w_res.status        = (r_hmeta.refs == REFS_MAX) ? ST_OVER : ST_OK;
                end else if (r_best < ENTRIES) begin
                    // Miss: retag the oldest free entry, it needs a fill
                    w_meta_we           = 1'b1;
                    w_meta_wa           = r_victim;
                    w_meta_wd.is_tagged = 1'b1;
                    w_meta_wd.valid     = 1'b1;
                    w_meta_wd.refs      = 16'd1;
                    w_tag_we            = 1'b1;
                    w_res.slot          = 7'(r_victim);
                    w_res.fill_needed   = 1'b1;
                end else begin
                    w_res.status = ST_NOFREE;
                end
            end
            S_SLOT: begin
                w_meta_wa = r_slot;
                w_meta_wd = r_rd_meta;
                if (r_mode == MODE_PIN) begin
                    if (r_rd_meta.refs == REFS_MAX) begin
                        w_res.status = ST_OVER;
                    end else begin
                        w_meta_we      = 1'b1;
                        w_meta_wd.refs = r_rd_meta.refs + 1'b1;
                    end
                end else if (r_rd_meta.refs == '0) begin
                    w_res.status = ST_UNDER;
                end else begin
                    w_meta_we      = 1'b1;
                    w_meta_wd.refs = r_rd_meta.refs - 1'b1;
                    w_move         = (r_mode == MODE_RELEASE) && (r_rd_meta.refs == 16'd1);
                end
            end
            S_SWEEP: begin
                // Entry moves to the top, those above it shift down
                w_rank_we = r_rd_ok;
                w_rank_wa = r_rd_idx;
                if (r_rd_idx == r_slot) w_rank_wd = LAST_IDX;
                else if (r_rd_rank > r_mv_rank) w_rank_wd = r_rd_rank - 1'b1;
                else w_rank_wd = r_rd_rank;
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_idx   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok  <= w_issue;
            r_rd_idx <= w_raddr;
            unique case (r_state)
                S_INIT: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx[IDX_W-1:0] == LAST_IDX) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mode <= t_mode'(w_in_mode);
                        r_dev  <= s_axis_tdata[34:3];
                        r_blk  <= s_axis_tdata[66:35];
                        r_run  <= ({1'b0, w_in_run} > RUN_CAP) ? RUN_CAP : {1'b0, w_in_run};
                        r_slot <= IDX_W'(w_in_slot);
                        r_hit  <= 1'b0;
                        r_rhit <= 1'b0;
                        r_best <= ENTRIES;
                        r_res  <= '0;
                        unique case (w_in_mode) inside
                            MODE_GET, MODE_RANGE: begin
                                r_idx   <= '0;
                                r_state <= S_SCAN;
                            end
                            MODE_RELEASE, MODE_PIN, MODE_UNPIN: begin
                                r_idx <= CNT_W'(w_in_slot);
                                if ({25'd0, w_in_slot} < 32'(BUFFER_COUNT)) r_state <= S_SREAD;
                                else r_state <= S_OUT;
                            end
                            default: begin
                                r_idx   <= '0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Issue the next read, check the registered one
                    if (w_issue) r_idx <= r_idx + 1'b1;
                    if (r_rd_ok) begin
                        if (w_tag_hit && !r_hit) begin
                            r_hit   <= 1'b1;
                            r_found <= r_rd_idx;
                            r_hmeta <= r_rd_meta;
                        end
                        if (w_better) begin
                            r_best   <= {1'b0, r_rd_rank};
                            r_victim <= r_rd_idx;
                        end
                        if (w_rng_hit) r_rhit <= 1'b1;
                        if (r_rd_idx == LAST_IDX) r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_res   <= w_res;
                    r_state <= S_OUT;
                end
                S_SREAD: r_state <= S_SLOT;
                S_SLOT: begin
                    r_res <= w_res;
                    if (w_move) begin
                        r_mv_rank <= r_rd_rank;
                        r_idx     <= '0;
                        r_state   <= S_SWEEP;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SWEEP: begin
                    if (w_issue) r_idx <= r_idx + 1'b1;
                    if (r_rd_ok && r_rd_idx == LAST_IDX) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result register: loads when empty or being taken
    assign w_out_load = (r_state == S_OUT) && (!r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
            r_out     <= {4'd0, r_res};
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end
endmodule

### tb/sv/block_buffer_cache_lru_unit_chk.sv
// Checker for the buffer cache unit: predicts each response and compares it.
`timescale 1ns / 1ps
module block_buffer_cache_lru_unit_chk
    import bbc_pkg::*;
#(
    parameter int BUFFER_COUNT = 128,
    parameter int MAX_RUN      = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [87:0] i_req_data,     // mode, block_device, block_number, run_length, slot_in
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [15:0] i_rsp_data,     // slot_out, was_hit, fill_needed, range_hit, status
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0] status;
        logic       range_hit;
        logic       fill;
        logic       was_hit;
        logic [6:0] slot;
    } t_rsp;

    // Shadow copy of the cache directory
    logic [31:0]       tag_dev    [BUFFER_COUNT];
    logic [31:0]       tag_blk    [BUFFER_COUNT];
    logic              ent_tagged [BUFFER_COUNT];
    logic              valid      [BUFFER_COUNT];
    logic [REFS_W-1:0] refs       [BUFFER_COUNT];
    int                rank       [BUFFER_COUNT];
    t_rsp              rsp_queue  [$];

    assign o_pending = rsp_queue.size();

    function automatic void promote(int s);
        int r;
        r = rank[s];
        for (int i = 0; i < BUFFER_COUNT; i++)
            if (rank[i] > r) rank[i]--;
        rank[s] = BUFFER_COUNT - 1;
    endfunction

    function automatic logic [1:0] ref_inc(int s);
        if (refs[s] == REFS_MAX) return ST_OVER;
        refs[s]++;
        return ST_OK;
    endfunction

    function automatic logic [1:0] ref_dec(int s, bit move);
        if (refs[s] == 0) return ST_UNDER;
        refs[s]--;
        if (move && refs[s] == 0) promote(s);
        return ST_OK;
    endfunction

    function automatic t_rsp cache_lookup(logic [87:0] d);
        t_rsp        r;
        logic [2:0]  m;
        logic [31:0] dev, blk;
        int          run, slot, found, best;
        r = '0;
        m = d[2:0]; dev = d[34:3]; blk = d[66:35]; run = d[74:67]; slot = d[81:75];
        found = BUFFER_COUNT;
        case (m)
            MODE_GET: begin
                for (int i = 0; i < BUFFER_COUNT; i++)
                    if (found == BUFFER_COUNT && ent_tagged[i] && tag_dev[i] == dev
                        && tag_blk[i] == blk) found = i;
                if (found < BUFFER_COUNT) begin
                    r.status = ref_inc(found);
                    r.was_hit = 1'b1;
                end else begin
                    best = BUFFER_COUNT;
                    for (int i = 0; i < BUFFER_COUNT; i++)
                        if (refs[i] == 0 && rank[i] < best) begin
                            best = rank[i];
                            found = i;
                        end
                    if (found < BUFFER_COUNT) begin
                        tag_dev[found] = dev; tag_blk[found] = blk;
                        ent_tagged[found] = 1'b1; valid[found] = 1'b0; refs[found] = 16'd1;
                    end else r.status = ST_NOFREE;
                end
                if (found < BUFFER_COUNT) begin
                    r.slot = found[6:0];
                    r.fill = !valid[found];
                    valid[found] = 1'b1;
                end
            end
            MODE_RELEASE: if (slot < BUFFER_COUNT) r.status = ref_dec(slot, 1'b1);
            MODE_PIN:     if (slot < BUFFER_COUNT) r.status = ref_inc(slot);
            MODE_UNPIN:   if (slot < BUFFER_COUNT) r.status = ref_dec(slot, 1'b0);
            MODE_RANGE: begin
                if (run > MAX_RUN) run = MAX_RUN;
                for (int i = 0; i < BUFFER_COUNT; i++)
                    if (ent_tagged[i] && valid[i] && tag_dev[i] == dev
                        && 32'(tag_blk[i] - blk) < run) r.range_hit = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Predict on request transactions, compare on response transactions
    always @(posedge i_clk) begin
        t_rsp got, exp_rsp;
        if (!i_rst_n) begin
            for (int i = 0; i < BUFFER_COUNT; i++) begin
                ent_tagged[i] = 1'b0; valid[i] = 1'b0; refs[i] = '0; rank[i] = i;
                tag_dev[i] = '0; tag_blk[i] = '0;
            end
            rsp_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_data[11:0];
                if (rsp_queue.size() == 0) begin
                    $display("%0t: unexpected response %h", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_rsp = rsp_queue.pop_front();
                    if (got !== exp_rsp) begin
                        $display("%0t: mismatch expected slot=%0d hit=%b fill=%b rhit=%b st=%0d",
                                 $realtime, exp_rsp.slot, exp_rsp.was_hit, exp_rsp.fill,
                                 exp_rsp.range_hit, exp_rsp.status);
                        $display("%0t:          actual   slot=%0d hit=%b fill=%b rhit=%b st=%0d",
                                 $realtime, got.slot, got.was_hit, got.fill,
                                 got.range_hit, got.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_req_valid && i_req_ready) rsp_queue.push_back(cache_lookup(i_req_data));
        end
    end

endmodule

### tb/sv/block_buffer_cache_lru_unit_tb.sv
// Top of the buffer cache testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module block_buffer_cache_lru_unit_tb
    import bbc_pkg::*;
;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [87:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_data;
    int          fail_count, pending;
    int          idle_cycles = 0;
    bit          hold_rsp = 1'b0, calm = 1'b0;
    int          n_get = 0, n_range = 0;

    // Small pools so gets hit often and the cache fills
    logic [31:0] dev_pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000};
    logic [6:0]  held_slots [$];

    always #1 i_clk = ~i_clk;

    block_buffer_cache_lru_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data)
    );

    block_buffer_cache_lru_unit_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_valid), .i_req_ready(s_ready), .i_req_data(s_data),
        .i_rsp_valid(m_valid), .i_rsp_ready(m_ready), .i_rsp_data(m_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Send one request transaction, with random idle before it
    task automatic issue(logic [2:0] m, logic [31:0] dev, logic [31:0] blk,
                         logic [7:0] run, logic [6:0] slot);
        if (!calm && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 33);
        end
        s_valid <= 1'b1;
        s_data  <= {6'b0, slot, run, blk, dev, m};
        do @(posedge i_clk); while (!s_ready);
        if (m == MODE_GET) n_get++;
        if (m == MODE_RANGE) n_range++;
    endtask

    // Response side: random stalls, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) m_ready <= 1'b0;
        else m_ready <= !hold_rsp && (calm || $urandom_range(99) >= 33);
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] rnd_blk();
        case ($urandom_range(3))
            0: return $urandom_range(40);
            1: return 32'hFFFF_FFFF - $urandom_range(10);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [2:0] m;
        logic [6:0] sl;
        int         sel;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each mode and the corner cases
        issue(MODE_RANGE, 32'h0, 32'h0, 8'd5, 7'd0);                     // empty cache
        issue(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 7'd0);       // miss, fill
        issue(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 7'd0);       // hit
        issue(MODE_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 8'd255, 7'd0);   // run clipped
        issue(MODE_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 7'd0);     // zero length
        issue(MODE_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 8'd3, 7'd0);     // hits at edge
        issue(MODE_GET, 32'h0, 32'h1, 8'd0, 7'd0);
        issue(MODE_RANGE, 32'h0, 32'hFFFF_FFFF, 8'd2, 7'd0);             // wraps to zero
        issue(MODE_RELEASE, 32'd0, 32'd0, 8'd0, 7'd0);
        issue(MODE_RELEASE, 32'd0, 32'd0, 8'd0, 7'd0);                   // to zero, moves
        issue(MODE_RELEASE, 32'd0, 32'd0, 8'd0, 7'd0);                   // underflow
        issue(MODE_UNPIN, 32'd0, 32'd0, 8'd0, 7'd127);                   // underflow
        issue(MODE_PIN, 32'd0, 32'd0, 8'd0, 7'd1);
        issue(MODE_UNPIN, 32'd0, 32'd0, 8'd0, 7'd1);                     // unpin, count back to one
        issue(3'd5, 32'hFFFF_FFFF, 32'd0, 8'hFF, 7'h7F);                 // unknown modes
        issue(3'd6, 32'd0, 32'hFFFF_FFFF, 8'd0, 7'd0);
        issue(3'd7, 32'h5555_5555, 32'hAAAA_AAAA, 8'h55, 7'h2A);
        // Fill all slots with references, then a miss has no free buffer
        for (int i = 0; i < 130; i++) issue(MODE_GET, 32'h7, 32'(i), 8'd0, 7'd0);
        for (int i = 0; i < 128; i++) issue(MODE_UNPIN, 32'd0, 32'd0, 8'd0, i[6:0]);

        // Random part; a calm stretch in the middle
        for (int n = 0; n < 975; n++) begin
            calm = (n >= 400 && n < 500);
            if (n == 700) fork
                begin
                    hold_rsp = 1'b1;
                    repeat (300) @(posedge i_clk);
                    hold_rsp = 1'b0;
                end
            join_none
            sel = $urandom_range(99);
            if (sel < 45) begin
                m = MODE_GET;
            end else if (sel < 65) m = MODE_RELEASE;
            else if (sel < 73) m = MODE_PIN;
            else if (sel < 80) m = MODE_UNPIN;
            else if (sel < 95) m = MODE_RANGE;
            else m = 3'($urandom_range(5, 7));
            sl = (held_slots.size() && $urandom_range(3)) ?
                 held_slots[$urandom_range(held_slots.size() - 1)] : 7'($urandom);
            issue(m, dev_pool[$urandom_range(3)] ^ ($urandom_range(9) == 0 ? $urandom : 0),
                  ($urandom_range(1) ? 32'($urandom_range(60)) : rnd_blk()),
                  8'($urandom_range(9) == 0 ? $urandom : $urandom_range(20)), sl);
            if (m == MODE_GET && held_slots.size() < 64) held_slots.push_back(7'($urandom));
        end
        s_valid <= 1'b0;

        // Drain and verdict
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        $display("Covered %0d gets and %0d range checks among mixed refcount requests,",
                 n_get, n_range);
        $display("including a full cache, underflow, unknown modes and a long output stall.");
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
